@@ rtl/wgft_pkg.sv @@
// Shared types, constants and the scaled filter-transform matrix for the
// Winograd F(4x4,3x3) filter transform block. No dependencies.
package wgft_pkg;

  localparam int WEIGHT_WIDTH = 16;
  localparam int BUF_WIDTH    = WEIGHT_WIDTH + 4;
  localparam int ROWS         = 6;
  localparam int TAPS         = 3;
  localparam int ROW_W        = 3;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // Column pass: x = 2 * (G24 g), then round(x / 3) = floor((x + 1) / 3),
  // done as a biased reciprocal multiply.
  localparam int CX_W = WEIGHT_WIDTH + 6;
  localparam int CY_W = WEIGHT_WIDTH + 7;
  localparam int CSH  = CY_W + 1;
  localparam logic [CY_W-1:0] C_YOFF  = CY_W'((64'd3 << (WEIGHT_WIDTH + 5)) + 64'd1);
  localparam logic [CY_W-1:0] C_RECIP = CY_W'(((64'd1 << CSH) + 64'd2) / 64'd3);
  localparam logic [CY_W-2:0] C_QOFF  = (CY_W-1)'(64'd1 << (WEIGHT_WIDTH + 5));

  // Row pass: floor((s + 192) / 384) = floor(floor((s + 192) / 128) / 3).
  localparam int RS_W    = WEIGHT_WIDTH + 9;
  localparam int RND_SH  = 7;
  localparam int RND_HALF = 192;
  localparam int RY_W    = WEIGHT_WIDTH + 3;
  localparam int RSH     = RY_W + 1;
  localparam int RQ_W    = RY_W - 1;
  localparam logic [RY_W-1:0] R_YOFF  = RY_W'(64'd3 << (WEIGHT_WIDTH + 1));
  localparam logic [RY_W-1:0] R_RECIP = RY_W'(((64'd1 << RSH) + 64'd2) / 64'd3);
  localparam logic [RQ_W-1:0] R_QOFF  = RQ_W'(64'd1 << (WEIGHT_WIDTH + 1));
  localparam logic signed [RQ_W-1:0] R_SAT_HI =
    RQ_W'((64'sd1 <<< (WEIGHT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RQ_W-1:0] R_SAT_LO =
    RQ_W'(-(64'sd1 <<< (WEIGHT_WIDTH - 1)));

  // Row FIFO between the column pass and the row pass
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
  typedef logic signed [BUF_WIDTH-1:0]    buf_t;
  typedef logic signed [5:0]              coef_t;

  // One row of the column-pass buffer, tagged with its tile row
  typedef struct packed {
    logic [ROW_W-1:0] row;
    buf_t             b0;
    buf_t             b1;
    buf_t             b2;
  } colrow_t;

  // G scaled by 24
  localparam coef_t G24 [ROWS][TAPS] = '{
    '{ 6'sd6,  6'sd0,  6'sd0},
    '{-6'sd4, -6'sd4, -6'sd4},
    '{-6'sd4,  6'sd4, -6'sd4},
    '{ 6'sd1,  6'sd2,  6'sd4},
    '{ 6'sd1, -6'sd2,  6'sd4},
    '{ 6'sd0,  6'sd0,  6'sd24}
  };

endpackage

@@ rtl/wgft_if.sv @@
// Valid/ready channel interfaces for the kernel input and the tile-row output.
// Depends on wgft_pkg for the payload types.
interface wgft_in_if import wgft_pkg::*; ();
  logic    valid;
  logic    ready;
  weight_t w_r0c0, w_r0c1, w_r0c2;
  weight_t w_r1c0, w_r1c1, w_r1c2;
  weight_t w_r2c0, w_r2c1, w_r2c2;

  modport source (output valid, w_r0c0, w_r0c1, w_r0c2, w_r1c0, w_r1c1, w_r1c2,
                  w_r2c0, w_r2c1, w_r2c2, input ready);
  modport sink   (input valid, w_r0c0, w_r0c1, w_r0c2, w_r1c0, w_r1c1, w_r1c2,
                  w_r2c0, w_r2c1, w_r2c2, output ready);
endinterface

interface wgft_out_if import wgft_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  weight_t          u_c0, u_c1, u_c2, u_c3, u_c4, u_c5;
  logic             last_row;

  modport source (output valid, row_index, u_c0, u_c1, u_c2, u_c3, u_c4, u_c5,
                  last_row, input ready);
  modport sink   (input valid, row_index, u_c0, u_c1, u_c2, u_c3, u_c4, u_c5,
                  last_row, output ready);
endinterface

@@ rtl/wgft_front.sv @@
// Front end: accepts kernels and sequences the column pass in a two-stage
// pipeline, one buffer row per cycle unless stalled. Uses wgft_pkg, wgft_if.
module wgft_front import wgft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wgft_in_if.sink   in_ch,
  output colrow_t   push_data,
  output logic      push_valid,
  input  logic      push_ready
);

  function automatic logic [CY_W-1:0] col_y(input logic [ROW_W-1:0] r,
                                            input weight_t a0, a1, a2);
    logic signed [CX_W-1:0] s;
    s = CX_W'(G24[r][0]) * CX_W'(a0) + CX_W'(G24[r][1]) * CX_W'(a1)
      + CX_W'(G24[r][2]) * CX_W'(a2);
    return CY_W'(s <<< 1) + C_YOFF;
  endfunction

  weight_t          kern_r   [TAPS][TAPS];
  weight_t          kern_nxt [TAPS][TAPS];
  logic             busy_r, busy_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             f1_v_r, f1_v_nxt;
  logic [ROW_W-1:0] f1_row_r, f1_row_nxt;
  logic [CY_W-1:0]  f1_y_r   [TAPS];
  logic [CY_W-1:0]  f1_y_nxt [TAPS];

  logic             f2_v_r, f2_v_nxt;
  colrow_t          f2_d_r, f2_d_nxt;

  logic             f1_rdy, f2_rdy, issue, accept;
  logic [2*CY_W-1:0] prod [TAPS];
  logic [CY_W-2:0]   quo  [TAPS];

  assign f2_rdy      = !f2_v_r || push_ready;
  assign f1_rdy      = !f1_v_r || f2_rdy;
  assign issue       = busy_r && f1_rdy;
  assign in_ch.ready = !busy_r || (issue && (row_r == LAST_ROW));
  assign accept      = in_ch.valid && in_ch.ready;

  // Kernel hold and row sequencer
  always_comb begin
    kern_nxt = kern_r;
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (issue) begin
      row_nxt = row_r + ROW_W'(1);
      if (row_r == LAST_ROW) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      kern_nxt = '{'{in_ch.w_r0c0, in_ch.w_r0c1, in_ch.w_r0c2},
                   '{in_ch.w_r1c0, in_ch.w_r1c1, in_ch.w_r1c2},
                   '{in_ch.w_r2c0, in_ch.w_r2c1, in_ch.w_r2c2}};
    end
  end

  // Stage 1: weighted column sums, biased for the divide by three
  always_comb begin
    f1_v_nxt   = f1_v_r;
    f1_row_nxt = f1_row_r;
    f1_y_nxt   = f1_y_r;
    if (f1_rdy) begin
      f1_v_nxt   = issue;
      f1_row_nxt = row_r;
      for (int c = 0; c < TAPS; c++) begin
        f1_y_nxt[c] = col_y(row_r, kern_r[0][c], kern_r[1][c], kern_r[2][c]);
      end
    end
  end

  // Stage 2: reciprocal multiply, drop the bias
  always_comb begin
    for (int c = 0; c < TAPS; c++) begin
      prod[c] = (2*CY_W)'(f1_y_r[c]) * (2*CY_W)'(C_RECIP);
      quo[c]  = prod[c][2*CY_W-1:CSH] - C_QOFF;
    end
    f2_v_nxt = f2_v_r;
    f2_d_nxt = f2_d_r;
    if (f2_rdy) begin
      f2_v_nxt    = f1_v_r;
      f2_d_nxt.row = f1_row_r;
      f2_d_nxt.b0  = BUF_WIDTH'(quo[0]);
      f2_d_nxt.b1  = BUF_WIDTH'(quo[1]);
      f2_d_nxt.b2  = BUF_WIDTH'(quo[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      f1_v_r <= f1_v_nxt;
      f2_v_r <= f2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kern_r   <= kern_nxt;
    f1_row_r <= f1_row_nxt;
    f1_y_r   <= f1_y_nxt;
    f2_d_r   <= f2_d_nxt;
  end

  assign push_valid = f2_v_r;
  assign push_data  = f2_d_r;

endmodule

@@ rtl/wgft_queue.sv @@
// Small FIFO of column-pass rows between the front and back ends.
// Depends on wgft_pkg.
module wgft_queue import wgft_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  colrow_t push_data,
  input  logic    push_valid,
  output logic    push_ready,
  output colrow_t pop_data,
  output logic    pop_valid,
  input  logic    pop_ready
);

  colrow_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/wgft_back.sv @@
// Back end: row pass, one buffered row per cycle unless stalled, six lanes,
// rounding and saturation into the output register. Uses wgft_pkg, wgft_if.
module wgft_back import wgft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  colrow_t   pop_data,
  input  logic      pop_valid,
  output logic      pop_ready,
  wgft_out_if.source out_ch
);

  function automatic logic [RY_W-1:0] row_y(input logic [ROW_W-1:0] k,
                                            input buf_t b0, b1, b2);
    logic signed [RS_W-1:0] s;
    logic signed [RS_W-1:0] sr;
    s  = RS_W'(G24[k][0]) * RS_W'(b0) + RS_W'(G24[k][1]) * RS_W'(b1)
       + RS_W'(G24[k][2]) * RS_W'(b2);
    sr = s + RS_W'(RND_HALF);
    return RY_W'($signed(sr[RS_W-1:RND_SH])) + R_YOFF;
  endfunction

  logic             b1_v_r, b1_v_nxt;
  logic [ROW_W-1:0] b1_row_r, b1_row_nxt;
  logic [RY_W-1:0]  b1_y_r   [ROWS];
  logic [RY_W-1:0]  b1_y_nxt [ROWS];

  logic             o_v_r, o_v_nxt;
  logic [ROW_W-1:0] o_row_r, o_row_nxt;
  logic             o_last_r, o_last_nxt;
  weight_t          o_u_r   [ROWS];
  weight_t          o_u_nxt [ROWS];

  logic              b1_rdy, o_rdy;
  logic [2*RY_W-1:0] prod [ROWS];
  logic signed [RQ_W-1:0] val [ROWS];

  assign o_rdy     = !o_v_r || out_ch.ready;
  assign b1_rdy    = !b1_v_r || o_rdy;
  assign pop_ready = b1_rdy;

  // Stage 1: six row sums, round off the power-of-two part, bias
  always_comb begin
    b1_v_nxt   = b1_v_r;
    b1_row_nxt = b1_row_r;
    b1_y_nxt   = b1_y_r;
    if (b1_rdy) begin
      b1_v_nxt   = pop_valid;
      b1_row_nxt = pop_data.row;
      for (int k = 0; k < ROWS; k++) begin
        b1_y_nxt[k] = row_y(ROW_W'(k), pop_data.b0, pop_data.b1, pop_data.b2);
      end
    end
  end

  // Stage 2: divide by three, saturate into the output register
  always_comb begin
    for (int k = 0; k < ROWS; k++) begin
      prod[k] = (2*RY_W)'(b1_y_r[k]) * (2*RY_W)'(R_RECIP);
      val[k]  = $signed(prod[k][2*RY_W-1:RSH] - R_QOFF);
    end
    o_v_nxt    = o_v_r;
    o_row_nxt  = o_row_r;
    o_last_nxt = o_last_r;
    o_u_nxt    = o_u_r;
    if (o_rdy) begin
      o_v_nxt    = b1_v_r;
      o_row_nxt  = b1_row_r;
      o_last_nxt = (b1_row_r == LAST_ROW);
      for (int k = 0; k < ROWS; k++) begin
        if (val[k] > R_SAT_HI) begin
          o_u_nxt[k] = WEIGHT_WIDTH'(R_SAT_HI);
        end else if (val[k] < R_SAT_LO) begin
          o_u_nxt[k] = WEIGHT_WIDTH'(R_SAT_LO);
        end else begin
          o_u_nxt[k] = WEIGHT_WIDTH'(val[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_row_r <= b1_row_nxt;
    b1_y_r   <= b1_y_nxt;
    o_row_r  <= o_row_nxt;
    o_last_r <= o_last_nxt;
    o_u_r    <= o_u_nxt;
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.row_index = o_row_r;
  assign out_ch.last_row  = o_last_r;
  assign out_ch.u_c0      = o_u_r[0];
  assign out_ch.u_c1      = o_u_r[1];
  assign out_ch.u_c2      = o_u_r[2];
  assign out_ch.u_c3      = o_u_r[3];
  assign out_ch.u_c4      = o_u_r[4];
  assign out_ch.u_c5      = o_u_r[5];

endmodule

@@ rtl/winograd_f4x4_3x3_filter_transform.sv @@
// Winograd F(4x4,3x3) filter transform, U = G g G^T, top level.
// Depends on wgft_pkg, wgft_if, wgft_front, wgft_queue, wgft_back.
//
// Usage:
//   in_ch carries one 3x3 kernel of signed Q1.15 weights per transaction.
//   out_ch returns the 6x6 transformed tile as six transactions, one per
//   tile row (row_index 0..5), six Q1.15 values each, rounded to nearest
//   and saturated; last_row marks row 5.
// Timing:
//   Once the first row of a kernel shows on out_ch, the remaining rows
//   follow one per cycle while out_ch.ready stays high. The front end
//   issues one column-pass row per cycle unless backpressure holds it, so
//   its row sequencer sets the kernel rate. in_ch.ready rises again in
//   the cycle the last row of the current kernel is issued.
// Reset (rst_n low, synchronous): clears all valid flags, the row
//   sequencer and the row FIFO; no kernel is in flight afterwards.
// Backpressure: when out_ch.ready is low the output register holds; the
//   back end, the four-entry row FIFO and the front pipeline fill in turn,
//   then the front stops issuing rows and in_ch.ready drops.
module winograd_f4x4_3x3_filter_transform import wgft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wgft_in_if.sink     in_ch,
  wgft_out_if.source  out_ch
);

  colrow_t q_in_data;
  logic    q_in_valid;
  logic    q_in_ready;
  colrow_t q_out_data;
  logic    q_out_valid;
  logic    q_out_ready;

  // Accept kernels, compute column-pass rows
  wgft_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_data  (q_in_data),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready)
  );

  // Decouple the two passes so each side can stall on its own
  wgft_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (q_in_data),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .pop_data   (q_out_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready)
  );

  // Row pass and output register
  wgft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (q_out_data),
    .pop_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/sv/winograd_f4x4_3x3_filter_transform_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for winograd_f4x4_3x3_filter_transform: random and directed
// 3x3 kernels in, six predicted tile rows per kernel checked out.
// Depends on wgft_pkg, wgft_if and the RTL top level.
module winograd_f4x4_3x3_filter_transform_tb;
  import wgft_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_IDLE     = 19;
  localparam int SHOW_LIMIT   = 10;
  localparam int RANDOM_ITEMS = 50;  // per random segment, four segments

  localparam logic [WEIGHT_WIDTH-1:0] W_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
  localparam logic [WEIGHT_WIDTH-1:0] W_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
  localparam logic [WEIGHT_WIDTH-1:0] W_ONE = WEIGHT_WIDTH'(1);
  localparam logic [WEIGHT_WIDTH-1:0] W_NEG_ONE = '1;

  // Filter matrix G with every entry scaled by 24, so all sums stay integer
  localparam int XFORM24 [6][3] = '{
    '{ 6,  0,  0},
    '{-4, -4, -4},
    '{-4,  4, -4},
    '{ 1,  2,  4},
    '{ 1, -2,  4},
    '{ 0,  0, 24}
  };

  // One kernel, element r*3+c holds weight row r, column c
  typedef logic [8:0][WEIGHT_WIDTH-1:0] kernel_t;

  // One row of the transformed 6x6 tile as the output channel carries it
  typedef struct packed {
    logic [ROW_W-1:0]               row;
    logic [5:0][WEIGHT_WIDTH-1:0]   u;
    logic                           last;
  } tile_row_t;

  logic clk = 1'b0;
  logic rst_n;

  wgft_in_if  in_ch ();
  wgft_out_if out_ch ();

  winograd_f4x4_3x3_filter_transform dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Tile rows predicted for accepted kernels, oldest first
  tile_row_t tile_rows_due [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the transform
  // ---------------------------------------------------------------------------

  // Floor division for a positive divisor
  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Clamp to the signed range of the given width
  function automatic longint clamp_signed(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Compute U = G g G^T for one kernel and queue its six tile rows.
  // Column pass: 24*(G g) scaled to Q1.19 is 2s/3, rounded to nearest.
  // Row pass: the sum carries a 24 * 16 = 384 scale, rounded half up.
  function automatic void predict_tile(input kernel_t k);
    longint    col_pass [6][3];
    longint    acc;
    tile_row_t due;
    int        r;
    int        c;
    int        j;
    for (r = 0; r < 6; r++) begin
      for (c = 0; c < 3; c++) begin
        acc = 0;
        for (j = 0; j < 3; j++)
          acc += longint'(XFORM24[r][j]) * longint'($signed(k[j*3 + c]));
        col_pass[r][c] = clamp_signed(floor_div(4 * acc + 3, 6), BUF_WIDTH);
      end
    end
    for (r = 0; r < 6; r++) begin
      due.row = ROW_W'(r);
      for (c = 0; c < 6; c++) begin
        acc = 0;
        for (j = 0; j < 3; j++)
          acc += longint'(XFORM24[c][j]) * col_pass[r][j];
        due.u[c] = WEIGHT_WIDTH'(clamp_signed(floor_div(acc + 192, 384), WEIGHT_WIDTH));
      end
      due.last = (r == 5);
      tile_rows_due.push_back(due);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one kernel per transaction, driven at the falling edge
  // ---------------------------------------------------------------------------

  // Entered and left at a falling edge. Valid stays high across back-to-back
  // kernels; it only drops when an idle gap is drawn.
  task automatic send_kernel(input kernel_t k);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.w_r0c0 <= k[0];
    in_ch.w_r0c1 <= k[1];
    in_ch.w_r0c2 <= k[2];
    in_ch.w_r1c0 <= k[3];
    in_ch.w_r1c1 <= k[4];
    in_ch.w_r1c2 <= k[5];
    in_ch.w_r2c0 <= k[6];
    in_ch.w_r2c1 <= k[7];
    in_ch.w_r2c2 <= k[8];
    in_ch.valid  <= 1'b1;
    // Hold until the block takes the transaction
    do @(posedge clk); while (!in_ch.ready);
    predict_tile(k);
    @(negedge clk);
  endtask

  // Same weight in all nine positions
  function automatic kernel_t flat_kernel(input logic [WEIGHT_WIDTH-1:0] w);
    kernel_t k;
    int      n;
    for (n = 0; n < 9; n++) k[n] = w;
    return k;
  endfunction

  // Draw a kernel: mostly full-range weights, some small ones that sit near
  // rounding boundaries, some built from the range ends
  function automatic kernel_t random_kernel();
    kernel_t     k;
    int unsigned style;
    int          n;
    style = $urandom_range(0, 3);
    for (n = 0; n < 9; n++) begin
      case (style)
        2: begin
          k[n] = WEIGHT_WIDTH'(int'($urandom_range(0, 32)) - 16);
        end
        3: begin
          case ($urandom_range(0, 2))
            0:       k[n] = W_MAX;
            1:       k[n] = W_MIN;
            default: k[n] = WEIGHT_WIDTH'($urandom);
          endcase
        end
        default: begin
          k[n] = WEIGHT_WIDTH'($urandom);
        end
      endcase
    end
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls on ready, checked at the rising edge
  // ---------------------------------------------------------------------------

  initial begin : drive_sink_ready
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      // Draw a fresh stall for each row; with stall zero ready just stays high
      stall = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic report_mismatch(input string field, input longint due_v,
                                 input longint got_v);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field,
               due_v, got_v);
  endtask

  // Compare every output transaction with the oldest predicted row
  always @(posedge clk) begin : check_rows
    tile_row_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tile_rows_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("[%0t] unexpected tile row %0d with nothing pending", $realtime,
                   out_ch.row_index);
      end else begin
        due = tile_rows_due.pop_front();
        if (out_ch.row_index !== due.row)
          report_mismatch("row_index", longint'(due.row), longint'(out_ch.row_index));
        if (out_ch.u_c0 !== due.u[0])
          report_mismatch("u_c0", longint'($signed(due.u[0])), longint'(out_ch.u_c0));
        if (out_ch.u_c1 !== due.u[1])
          report_mismatch("u_c1", longint'($signed(due.u[1])), longint'(out_ch.u_c1));
        if (out_ch.u_c2 !== due.u[2])
          report_mismatch("u_c2", longint'($signed(due.u[2])), longint'(out_ch.u_c2));
        if (out_ch.u_c3 !== due.u[3])
          report_mismatch("u_c3", longint'($signed(due.u[3])), longint'(out_ch.u_c3));
        if (out_ch.u_c4 !== due.u[4])
          report_mismatch("u_c4", longint'($signed(due.u[4])), longint'(out_ch.u_c4));
        if (out_ch.u_c5 !== due.u[5])
          report_mismatch("u_c5", longint'($signed(due.u[5])), longint'(out_ch.u_c5));
        if (out_ch.last_row !== due.last)
          report_mismatch("last_row", longint'(due.last), longint'(out_ch.last_row));
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("winograd_f4x4_3x3_filter_transform_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero, both range ends, mixed signs and alternating bit patterns
  task automatic test_extremes();
    kernel_t k;
    int      n;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_kernel(flat_kernel('0));
    send_kernel(flat_kernel(W_MAX));
    send_kernel(flat_kernel(W_MIN));
    send_kernel(flat_kernel(W_ONE));
    send_kernel(flat_kernel(W_NEG_ONE));
    send_kernel(flat_kernel({(WEIGHT_WIDTH/2){2'b01}}));
    send_kernel(flat_kernel({(WEIGHT_WIDTH/2){2'b10}}));
    // Checkerboard of the range ends drives the largest row-pass sums
    for (n = 0; n < 9; n++) k[n] = (n % 2 == 0) ? W_MAX : W_MIN;
    send_kernel(k);
  endtask

  // One full-scale weight at each position, the rest zero
  task automatic test_unit_impulses();
    kernel_t k;
    int      n;
    for (n = 0; n < 9; n++) begin
      k = '0;
      k[n] = (n % 2 == 0) ? W_MAX : W_MIN;
      send_kernel(k);
    end
  endtask

  // Exact halves in the row pass: with only the bottom-right weight set to
  // +3 or -3, tile row 5 column 3 lands on a tie, which must round upward
  task automatic test_rounding_ties();
    kernel_t k;
    k = '0;
    k[8] = WEIGHT_WIDTH'(3);
    send_kernel(k);
    k[8] = WEIGHT_WIDTH'(-3);
    send_kernel(k);
    k = '0;
    k[0] = W_ONE;
    send_kernel(k);
  endtask

  task automatic test_random_kernels(input int count, input bit src_idle,
                                     input bit sink_idle);
    int n;
    src_idle_on  = src_idle;
    sink_idle_on = sink_idle;
    for (n = 0; n < count; n++) send_kernel(random_kernel());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.w_r0c0 <= '0;
    in_ch.w_r0c1 <= '0;
    in_ch.w_r0c2 <= '0;
    in_ch.w_r1c0 <= '0;
    in_ch.w_r1c1 <= '0;
    in_ch.w_r1c2 <= '0;
    in_ch.w_r2c0 <= '0;
    in_ch.w_r2c1 <= '0;
    in_ch.w_r2c2 <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes();
    test_unit_impulses();
    test_rounding_ties();
    // Random kernels under each mix of idling: full throughput, sender
    // gaps only, receiver stalls only (fills the row FIFO), then both
    test_random_kernels(RANDOM_ITEMS, 1'b0, 1'b0);
    test_random_kernels(RANDOM_ITEMS, 1'b1, 1'b0);
    test_random_kernels(RANDOM_ITEMS, 1'b0, 1'b1);
    test_random_kernels(RANDOM_ITEMS, 1'b1, 1'b1);

    in_ch.valid <= 1'b0;
    // Drain: every predicted row must come out, then watch for strays
    while (tile_rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("winograd_f4x4_3x3_filter_transform_tb: PASS");
    end else begin
      $display("winograd_f4x4_3x3_filter_transform_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/wgft_pkg.sv
rtl/wgft_if.sv
rtl/wgft_front.sv
rtl/wgft_queue.sv
rtl/wgft_back.sv
rtl/winograd_f4x4_3x3_filter_transform.sv
tb/sv/winograd_f4x4_3x3_filter_transform_tb.sv
